// File: rtl/core/assert_macros.svh
// Assertion macros shared by the calibration map RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/ttc_pkg.sv
// Types and fixed constants of the tip temperature calibration map.
// Used by the channel interfaces and the top level.
`timescale 1ns / 1ps
package ttc_pkg;
	localparam int W          = 16;
	localparam int PW         = 32;
	localparam int OUT_W      = 11;
	localparam int OUT_MAX    = 2047;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int MUL_STEPS  = 16;
	localparam int DIV_STEPS  = 32;
	localparam int CNT_W      = 5;
	localparam int SEARCH_ROUNDS = 20;

	typedef logic signed [W-1:0]  val_t;
	typedef logic signed [PW-1:0] wide_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_FWD, ST_LOAD, ST_MUL, ST_DIV, ST_FIN, ST_EVAL, ST_DONE
	} st_t;

	typedef enum logic [1:0] {PH_SEG, PH_FAH, PH_TC, PH_GUESS} ph_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RAW_LOW, CFG_RAW_MID, CFG_RAW_HIGH, CFG_TEMP_LOW,
		CFG_TEMP_MID, CFG_TEMP_HIGH, CFG_AMBIENT, CFG_MODE
	} cfg_idx_t;
endpackage

// File: rtl/core/ttc_ifs.sv
// Request and result channel interfaces of the calibration map.
// Depends on ttc_pkg for the result width.
`timescale 1ns / 1ps
interface ttc_in_if;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [10:0]       value;
	logic signed [7:0] ambient_now;
	modport source (output valid, cmd, value, ambient_now, input ready);
	modport sink (input valid, cmd, value, ambient_now, output ready);
endinterface

interface ttc_out_if;
	logic                       valid;
	logic                       ready;
	logic [ttc_pkg::OUT_W-1:0]  converted;
	logic                       exact;
	modport source (output valid, converted, exact, input ready);
	modport sink (input valid, converted, exact, output ready);
endinterface

// File: rtl/core/tip_temperature_calibration_map.sv
// Top level of the tip temperature calibration map: sequencer, serial multiplier and divider.
// Depends on ttc_pkg, the interfaces in ttc_ifs.sv and assert_macros.svh.
//
// The block converts a raw tip sensor reading into a display temperature (cmd 0), or a
// display temperature back into the raw reading that produces it (cmd 1), using three
// calibration points and an ambient correction. It takes one request at a time: ready is
// high only while it is idle, and the result is held in an output register until taken.
// Every linear map goes through one shared serial unit, which multiplies one bit per cycle
// and divides one quotient bit per cycle between a load and a finish step; a zero input span
// skips both. A forward conversion takes one map in Celsius and two in Fahrenheit. An
// inverse conversion costs one map for the initial guess in Celsius or two in Fahrenheit,
// then one forward conversion for each search round. It stops at the first round whose
// guess hits the target, or when all twenty rounds have run. Configuration may only be
// written while the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tip_temperature_calibration_map #(
	parameter int RAW_MAX         = 1023,
	parameter int FIXED_AMBIENT_C = 25,
	parameter int MIN_C           = 180,
	parameter int MAX_C           = 450,
	parameter int MIN_F           = 350,
	parameter int MAX_F           = 850
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ttc_in_if.sink                          in_ch,
	ttc_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [ttc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ttc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ttc_pkg::*;

	localparam val_t RAW_MAX_V = val_t'(RAW_MAX);
	localparam val_t RAW_MID_V = val_t'(RAW_MAX / 2);
	localparam val_t RAW_QTR_V = val_t'(RAW_MAX / 4);
	localparam val_t FIX_AMB_V = val_t'(FIXED_AMBIENT_C);
	localparam val_t MIN_C_V   = val_t'(MIN_C);
	localparam val_t MAX_C_V   = val_t'(MAX_C);
	localparam val_t MIN_F_V   = val_t'(MIN_F);
	localparam val_t MAX_F_V   = val_t'(MAX_F);

	function automatic val_t u10(input logic [9:0] x);
		return val_t'({{(W-10){1'b0}}, x});
	endfunction

	function automatic logic [W-1:0] magn(input val_t x);
		return x[W-1] ? (W)'(-x) : (W)'(x);
	endfunction

	function automatic wide_t clampw(input wide_t v, input wide_t lo, input wide_t hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Configuration registers.
	logic [9:0]        raw_low_q, raw_mid_q, raw_high_q;
	logic [9:0]        temp_low_q, temp_mid_q, temp_high_q;
	logic signed [7:0] amb_cal_q;
	logic [1:0]        flags_q;

	// Request and sequencing registers.
	st_t               st_q, st_d;
	ph_t               ph_q;
	logic              cmd_q, search_q;
	logic [10:0]       val_q;
	val_t              amb_q, fx_q, guess_q, left_q, right_q, target_q, h_q;
	logic [4:0]        round_q;

	// Operands of the map in progress and the serial arithmetic unit.
	val_t              op_x_q, op_a_q, op_b_q, op_c_q, op_d_q;
	logic [PW-1:0]     acc_q, mcand_q;
	logic [W-1:0]      mplier_q, den_q;
	logic [W:0]        rem_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [OUT_W-1:0]  conv_q;
	logic              exact_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_low_q   <= 10'd500;
			raw_mid_q   <= 10'd700;
			raw_high_q  <= 10'd950;
			temp_low_q  <= 10'd200;
			temp_mid_q  <= 10'd300;
			temp_high_q <= 10'd400;
			amb_cal_q   <= 8'sd25;
			flags_q     <= 2'd1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_RAW_LOW:   raw_low_q   <= cfg_data;
				CFG_RAW_MID:   raw_mid_q   <= cfg_data;
				CFG_RAW_HIGH:  raw_high_q  <= cfg_data;
				CFG_TEMP_LOW:  temp_low_q  <= cfg_data;
				CFG_TEMP_MID:  temp_mid_q  <= cfg_data;
				CFG_TEMP_HIGH: temp_high_q <= cfg_data;
				CFG_AMBIENT:   amb_cal_q   <= cfg_data[7:0];
				CFG_MODE:      flags_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Combinational helpers for the current step.
	val_t  dx, dy, dn, amb_off, tgt, seg_c_lo, seg_c_hi, nxt_c;
	wide_t qs, mres, t_seg, g1, g2, nxt;
	logic [W:0] rem_sh;
	logic       q_bit;

	always_comb begin
		dx = op_x_q - op_a_q;
		dy = op_d_q - op_c_q;
		dn = op_b_q - op_a_q;
		amb_off = amb_q - val_t'(amb_cal_q);
		if (flags_q[0]) begin
			tgt = val_t'(clampw(wide_t'(u10(val_q[9:0]) + (val_q[10] ? val_t'(1024) : '0)),
				wide_t'(MIN_C_V), wide_t'(MAX_C_V)));
		end else begin
			tgt = val_t'(clampw(wide_t'(u10(val_q[9:0]) + (val_q[10] ? val_t'(1024) : '0)),
				wide_t'(MIN_F_V), wide_t'(MAX_F_V)));
		end
		seg_c_lo = u10(temp_low_q) + amb_off;
		seg_c_hi = u10(temp_mid_q) + amb_off;
		qs = wide_t'(acc_q);
		mres = (neg_q ? -qs : qs) + wide_t'(op_c_q);
		t_seg = clampw(mres, '0, wide_t'(OUT_MAX));
		g1 = clampw(mres, '0, wide_t'(RAW_MAX_V));
		g2 = (g1 > wide_t'(RAW_MID_V)) ? g1 - wide_t'(RAW_QTR_V) : g1 + wide_t'(RAW_QTR_V);
		g2 = clampw(g2, '0, wide_t'(RAW_MAX_V));
		// Bisection step: the midpoint moves by one where it would repeat the guess.
		if (h_q < target_q) begin
			nxt_c = (guess_q + right_q) >>> 1;
			if (nxt_c == guess_q) nxt_c = guess_q + val_t'(1);
		end else begin
			nxt_c = (left_q + guess_q) >>> 1;
			if (nxt_c == guess_q) nxt_c = guess_q - val_t'(1);
		end
		nxt = clampw(wide_t'(nxt_c), '0, wide_t'(RAW_MAX_V));
		rem_sh = {rem_q[W-1:0], acc_q[PW-1]};
		q_bit = (rem_sh >= {1'b0, den_q});
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:  if (in_ch.valid) st_d = ST_START;
			ST_START: st_d = cmd_q ? ST_LOAD : ST_FWD;
			ST_FWD:   st_d = ST_LOAD;
			ST_LOAD:  st_d = (dn == '0) ? ST_FIN : ST_MUL;
			ST_MUL:   if (cnt_q == CNT_W'(MUL_STEPS - 1)) st_d = ST_DIV;
			ST_DIV:   if (cnt_q == CNT_W'(DIV_STEPS - 1)) st_d = ST_FIN;
			ST_FIN: begin
				case (ph_q)
					PH_SEG:   st_d = flags_q[0] ? ST_EVAL : ST_LOAD;
					PH_FAH:   st_d = ST_EVAL;
					PH_TC:    st_d = ST_LOAD;
					PH_GUESS: st_d = ST_FWD;
					default:  st_d = ST_IDLE;
				endcase
			end
			ST_EVAL: begin
				if (!search_q || h_q == target_q || round_q == 5'(SEARCH_ROUNDS - 1)) begin
					st_d = ST_DONE;
				end else begin
					st_d = ST_FWD;
				end
			end
			ST_DONE:  if (out_ch.ready) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	// Datapath.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					cmd_q <= in_ch.cmd;
					val_q <= in_ch.value;
					amb_q <= flags_q[1] ? val_t'(in_ch.ambient_now) : FIX_AMB_V;
				end
			end
			ST_START: begin
				search_q <= cmd_q;
				fx_q     <= val_t'({{(W-11){1'b0}}, val_q});
				left_q   <= '0;
				right_q  <= RAW_MAX_V;
				target_q <= tgt;
				op_x_q   <= tgt;
				if (flags_q[0]) begin
					op_a_q <= u10(temp_low_q);
					op_b_q <= u10(temp_high_q);
					op_c_q <= u10(raw_low_q);
					op_d_q <= u10(raw_high_q);
					ph_q   <= PH_GUESS;
				end else begin
					op_a_q <= MIN_F_V;
					op_b_q <= MAX_F_V;
					op_c_q <= MIN_C_V;
					op_d_q <= MAX_C_V;
					ph_q   <= PH_TC;
				end
			end
			ST_FWD: begin
				// Segment choice: below the low point, from the middle point up, or between.
				op_x_q <= fx_q;
				ph_q   <= PH_SEG;
				if (fx_q < u10(raw_low_q)) begin
					op_a_q <= '0;
					op_b_q <= u10(raw_low_q);
					op_c_q <= amb_q;
					op_d_q <= u10(temp_low_q);
				end else if (fx_q >= u10(raw_mid_q)) begin
					op_a_q <= u10(raw_mid_q);
					op_b_q <= u10(raw_high_q);
					op_c_q <= seg_c_hi;
					op_d_q <= u10(temp_high_q) + amb_off;
				end else begin
					op_a_q <= u10(raw_low_q);
					op_b_q <= u10(raw_mid_q);
					op_c_q <= seg_c_lo;
					op_d_q <= seg_c_hi;
				end
			end
			ST_LOAD: begin
				cnt_q <= '0;
				rem_q <= '0;
				acc_q <= '0;
				if (dn == '0) begin
					// A zero input span gives the output value at the start of the span.
					neg_q <= 1'b0;
				end else begin
					neg_q    <= dx[W-1] ^ dy[W-1] ^ dn[W-1];
					mcand_q  <= {{(PW-W){1'b0}}, magn(dx)};
					mplier_q <= magn(dy);
					den_q    <= magn(dn);
				end
			end
			ST_MUL: begin
				if (mplier_q[0]) acc_q <= acc_q + mcand_q;
				mcand_q  <= {mcand_q[PW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[W-1:1]};
				cnt_q    <= (cnt_q == CNT_W'(MUL_STEPS - 1)) ? '0 : cnt_q + 1'b1;
			end
			ST_DIV: begin
				acc_q <= {acc_q[PW-2:0], q_bit};
				rem_q <= q_bit ? rem_sh - {1'b0, den_q} : rem_sh;
				cnt_q <= cnt_q + 1'b1;
			end
			ST_FIN: begin
				case (ph_q)
					PH_SEG: begin
						if (flags_q[0]) begin
							h_q <= val_t'(t_seg);
						end else begin
							op_x_q <= val_t'(t_seg);
							op_a_q <= MIN_C_V;
							op_b_q <= MAX_C_V;
							op_c_q <= MIN_F_V;
							op_d_q <= MAX_F_V;
							ph_q   <= PH_FAH;
						end
					end
					PH_FAH: h_q <= val_t'(t_seg);
					PH_TC: begin
						op_x_q <= val_t'(mres);
						op_a_q <= u10(temp_low_q);
						op_b_q <= u10(temp_high_q);
						op_c_q <= u10(raw_low_q);
						op_d_q <= u10(raw_high_q);
						ph_q   <= PH_GUESS;
					end
					PH_GUESS: begin
						guess_q <= val_t'(g2);
						fx_q    <= val_t'(g2);
						round_q <= '0;
					end
					default: ;
				endcase
			end
			ST_EVAL: begin
				if (!search_q) begin
					conv_q  <= h_q[OUT_W-1:0];
					exact_q <= 1'b1;
				end else if (h_q == target_q) begin
					conv_q  <= OUT_W'(clampw(wide_t'(guess_q), '0, wide_t'(OUT_MAX)));
					exact_q <= 1'b1;
				end else begin
					if (h_q < target_q) left_q <= guess_q;
					else right_q <= guess_q;
					guess_q <= val_t'(nxt);
					fx_q    <= val_t'(nxt);
					round_q <= round_q + 1'b1;
					conv_q  <= OUT_W'(clampw(nxt, '0, wide_t'(OUT_MAX)));
					exact_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		in_ch.ready      = (st_q == ST_IDLE);
		out_ch.valid     = (st_q == ST_DONE);
		out_ch.converted = conv_q;
		out_ch.exact     = exact_q;
	end

	`ASSERT_ALWAYS(a_one_side, !(in_ch.ready && out_ch.valid), "request taken while result held")
	`ASSERT_IMPLY(a_mul_count, st_q == ST_MUL, cnt_q < CNT_W'(MUL_STEPS), "multiply overran")
	`ASSERT_IMPLY(a_div_nonzero, st_q == ST_DIV, den_q != '0, "division by a zero span")
	`ASSERT_IMPLY(a_rounds, st_q == ST_EVAL && search_q, round_q < 5'(SEARCH_ROUNDS),
		"search ran past its round limit")
	`ASSERT_IMPLY(a_guess_range, st_q == ST_EVAL && search_q,
		guess_q >= val_t'(0) && guess_q <= RAW_MAX_V, "search guess out of raw range")
endmodule

// File: dv/tb_tip_temperature_calibration_map.sv
// Self-checking testbench for the tip temperature calibration map.
// Depends on ttc_pkg, the channel interfaces in ttc_ifs.sv and the top level of the block.
// A directed table is followed by random requests over several calibration settings.
`timescale 1ns / 1ps
module tb_tip_temperature_calibration_map;
	import ttc_pkg::*;

	localparam int RAW_MAX         = 1023;
	localparam int FIXED_AMBIENT_C = 25;
	localparam int MIN_C           = 180;
	localparam int MAX_C           = 450;
	localparam int MIN_F           = 350;
	localparam int MAX_F           = 850;
	localparam int TRIES           = 20;
	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 57;
	localparam int SETTLE_CYCLES   = 64;

	// The two conversion directions carried in the request.
	localparam logic CMD_TO_TEMP = 1'b0;
	localparam logic CMD_TO_RAW  = 1'b1;

	typedef struct packed {
		logic [OUT_W-1:0] converted;
		logic             exact;
	} reading_t;

	// One row of the directed table; known marks rows whose result is typed in.
	typedef struct {
		logic              cmd;
		logic [10:0]       value;
		logic signed [7:0] ambient;
		bit                known;
		reading_t          result;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ttc_in_if  in_ch();
	ttc_out_if out_ch();

	tip_temperature_calibration_map i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the calibration registers, kept in step with every write.
	logic [9:0]        raw_lo, raw_mid, raw_hi;
	logic [9:0]        temp_lo, temp_mid, temp_hi;
	logic signed [7:0] calib_ambient;
	logic [1:0]        flags;

	reading_t pending_readings[$];
	int       mismatches;
	bit       quiet;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Truncating linear map; a zero input span gives the output value c.
	function automatic longint scale(longint x, longint a, longint b, longint c, longint d);
		if (b == a)
			return c;
		return (x - a) * (d - c) / (b - a) + c;
	endfunction

	function automatic longint limit(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Raw reading to display temperature with the current calibration.
	function automatic longint raw_to_display(longint raw, longint amb);
		longint shift, t;
		shift = amb - longint'(calib_ambient);
		// Below the low point the curve starts from the ambient temperature at raw zero.
		if (raw < raw_lo)
			t = scale(raw, 0, raw_lo, amb, temp_lo);
		else if (raw >= raw_mid)
			t = scale(raw, raw_mid, raw_hi, temp_mid + shift, temp_hi + shift);
		else
			t = scale(raw, raw_lo, raw_mid, temp_lo + shift, temp_mid + shift);
		t = limit(t, 0, OUT_MAX);
		if (!flags[0])
			t = scale(t, MIN_C, MAX_C, MIN_F, MAX_F);
		return limit(t, 0, OUT_MAX);
	endfunction

	function automatic reading_t convert(logic cmd, logic [10:0] value,
			logic signed [7:0] amb_in);
		reading_t r;
		longint amb, target, celsius, left, right, guess, seen, nxt;
		amb = flags[1] ? longint'(amb_in) : FIXED_AMBIENT_C;
		r.exact = 1'b1;
		if (cmd == CMD_TO_TEMP) begin
			r.converted = OUT_W'(raw_to_display(value, amb));
			return r;
		end
		if (flags[0]) begin
			target  = limit(value, MIN_C, MAX_C);
			celsius = target;
		end else begin
			target  = limit(value, MIN_F, MAX_F);
			celsius = scale(target, MIN_F, MAX_F, MIN_C, MAX_C);
		end
		left  = 0;
		right = RAW_MAX;
		guess = limit(scale(celsius, temp_lo, temp_hi, raw_lo, raw_hi), 0, RAW_MAX);
		// The first guess is pulled a quarter of the range towards the middle.
		if (guess > (left + right) / 2)
			guess -= (right - left) / 4;
		else
			guess += (right - left) / 4;
		guess = limit(guess, 0, RAW_MAX);
		r.exact = 1'b0;
		for (int i = 0; i < TRIES; i++) begin
			seen = raw_to_display(guess, amb);
			if (seen == target) begin
				r.exact = 1'b1;
				break;
			end
			if (seen < target) begin
				left = guess;
				nxt  = (left + right) / 2;
				if (nxt == guess)
					nxt = guess + 1;
			end else begin
				right = guess;
				nxt   = (left + right) / 2;
				if (nxt == guess)
					nxt = guess - 1;
			end
			guess = limit(nxt, 0, RAW_MAX);
		end
		r.converted = OUT_W'(limit(guess, 0, OUT_MAX));
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// The receiver stalls at random, about 16 percent of the time, except in the quiet phase.
	always @(negedge clk)
		out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 16);

	// Every accepted result is checked against the oldest waiting expectation.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", out_ch.converted));
			end else begin
				want = pending_readings.pop_front();
				if (out_ch.converted !== want.converted)
					report_mismatch($sformatf("converted %0d, expected %0d",
						out_ch.converted, want.converted));
				if (out_ch.exact !== want.exact)
					report_mismatch($sformatf("exact %0b, expected %0b",
						out_ch.exact, want.exact));
			end
		end
	end

	task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_RAW_LOW:   raw_lo        = data;
			CFG_RAW_MID:   raw_mid       = data;
			CFG_RAW_HIGH:  raw_hi        = data;
			CFG_TEMP_LOW:  temp_lo       = data;
			CFG_TEMP_MID:  temp_mid      = data;
			CFG_TEMP_HIGH: temp_hi       = data;
			CFG_AMBIENT:   calib_ambient = data[7:0];
			CFG_MODE:      flags         = data[1:0];
			default: ;
		endcase
	endtask

	task automatic load_calibration(logic [9:0] rl, logic [9:0] rm, logic [9:0] rh,
			logic [9:0] tl, logic [9:0] tm, logic [9:0] th, logic signed [7:0] amb,
			logic [1:0] mode);
		write_register(CFG_RAW_LOW, rl);
		write_register(CFG_RAW_MID, rm);
		write_register(CFG_RAW_HIGH, rh);
		write_register(CFG_TEMP_LOW, tl);
		write_register(CFG_TEMP_MID, tm);
		write_register(CFG_TEMP_HIGH, th);
		write_register(CFG_AMBIENT, {2'b00, amb});
		write_register(CFG_MODE, {8'd0, mode});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offers one request and waits until taken; valid stays high unless dropped at random.
	task automatic send_request(logic cmd, logic [10:0] value, logic signed [7:0] amb,
			bit known, reading_t result);
		@(negedge clk);
		in_ch.valid       <= 1'b1;
		in_ch.cmd         <= cmd;
		in_ch.value       <= value;
		in_ch.ambient_now <= amb;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pending_readings.push_back(known ? result : convert(cmd, value, amb));
		if (!quiet && $urandom_range(99) < 16) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(5)) @(negedge clk);
		end
	endtask

	// Drops valid, then waits until every result is in and the block has settled.
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Directed rows. The typed results hold for the reset calibration: Celsius display,
	// fixed ambient, points (500,200), (700,300) and (950,400).
	row_t directed[] = '{
		'{CMD_TO_TEMP, 11'd500,  8'sd0,    1'b1, '{11'd200, 1'b1}},
		'{CMD_TO_TEMP, 11'd700,  8'sd0,    1'b1, '{11'd300, 1'b1}},
		'{CMD_TO_TEMP, 11'd950,  8'sd0,    1'b1, '{11'd400, 1'b1}},
		'{CMD_TO_TEMP, 11'd0,    -8'sd128, 1'b1, '{11'd25,  1'b1}},
		'{CMD_TO_TEMP, 11'd2047, 8'sd127,  1'b1, '{11'd838, 1'b1}},
		'{CMD_TO_TEMP, 11'd1023, 8'sd0,    1'b0, '{11'd0,   1'b0}},
		'{CMD_TO_TEMP, 11'd250,  8'sd60,   1'b0, '{11'd0,   1'b0}},
		'{CMD_TO_TEMP, 11'd699,  8'sd0,    1'b0, '{11'd0,   1'b0}},
		'{CMD_TO_RAW,  11'd0,    8'sd0,    1'b0, '{11'd0,   1'b0}},
		'{CMD_TO_RAW,  11'd2047, 8'sd0,    1'b0, '{11'd0,   1'b0}},
		'{CMD_TO_RAW,  11'd180,  8'sd127,  1'b0, '{11'd0,   1'b0}},
		'{CMD_TO_RAW,  11'd450,  -8'sd128, 1'b0, '{11'd0,   1'b0}},
		'{CMD_TO_RAW,  11'd300,  8'sd25,   1'b0, '{11'd0,   1'b0}},
		'{CMD_TO_RAW,  11'd333,  8'sd1,    1'b0, '{11'd0,   1'b0}},
		'{CMD_TO_RAW,  11'd1234, 8'sd0,    1'b0, '{11'd0,   1'b0}}
	};

	// Random requests: inverse targets lean towards the display range, raw readings
	// towards the sensor range, with the full eleven bits now and then.
	task automatic random_requests(int count);
		logic        cmd;
		logic [10:0] value;
		reading_t    none;
		none = '0;
		for (int n = 0; n < count; n++) begin
			cmd = ($urandom_range(99) < 40) ? CMD_TO_RAW : CMD_TO_TEMP;
			if ($urandom_range(9) == 0)
				value = 11'($urandom_range(2047));
			else if (cmd == CMD_TO_RAW)
				value = 11'($urandom_range(900, 150));
			else
				value = 11'($urandom_range(1023));
			send_request(cmd, value, 8'($urandom_range(255)), 1'b0, none);
		end
	endtask

	task automatic random_calibration();
		logic [9:0] r0, r1, r2, t0, t1, t2;
		// Mostly ordered points; sometimes fully random ones, including reversed spans.
		r0 = 10'($urandom_range(1023));
		r1 = 10'($urandom_range(1023));
		r2 = 10'($urandom_range(1023));
		t0 = 10'($urandom_range(1023));
		t1 = 10'($urandom_range(1023));
		t2 = 10'($urandom_range(1023));
		if ($urandom_range(3) != 0) begin
			r0 = 10'($urandom_range(600, 100));
			r1 = 10'(r0 + $urandom_range(250, 1));
			r2 = 10'(r1 + $urandom_range(150, 1));
			t0 = 10'($urandom_range(250, 100));
			t1 = 10'(t0 + $urandom_range(150, 10));
			t2 = 10'(t1 + $urandom_range(150, 10));
		end
		load_calibration(r0, r1, r2, t0, t1, t2, 8'($urandom_range(255)),
			2'($urandom_range(3)));
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_RAW_LOW;
		cfg_data          = '0;
		in_ch.valid       = 1'b0;
		in_ch.cmd         = CMD_TO_TEMP;
		in_ch.value       = '0;
		in_ch.ambient_now = '0;
		out_ch.ready      = 1'b0;
		quiet             = 1'b0;
		mismatches        = 0;
		raw_lo            = 10'd500;
		raw_mid           = 10'd700;
		raw_hi            = 10'd950;
		temp_lo           = 10'd200;
		temp_mid          = 10'd300;
		temp_hi           = 10'd400;
		calib_ambient     = 8'sd25;
		flags             = 2'd1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[k])
			send_request(directed[k].cmd, directed[k].value, directed[k].ambient,
				directed[k].known, directed[k].result);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				// Reset points in Fahrenheit with the measured ambient.
				0: load_calibration(10'd500, 10'd700, 10'd950, 10'd200, 10'd300, 10'd400,
					8'sd25, 2'd2);
				// Every register at its lowest: all spans are zero.
				1: load_calibration('0, '0, '0, '0, '0, '0, -8'sd128, 2'd0);
				// Every register at its highest.
				2: load_calibration('1, '1, '1, '1, '1, '1, 8'sd127, 2'd3);
				default: random_calibration();
			endcase
			// One phase runs without any idling on either side.
			quiet = (p == 5);
			random_requests(ITEMS_PER_PHASE);
			drain();
		end

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Worst case is a Fahrenheit inverse request over all rounds plus stalls; allow far more.
	initial begin
		#60ms;
		$display("Verification failed");
		$finish;
	end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ttc_pkg.sv
rtl/core/ttc_ifs.sv
rtl/core/tip_temperature_calibration_map.sv
dv/tb_tip_temperature_calibration_map.sv
